[src/slbi_pkg.sv]
`timescale 1ns / 1ps

package slbi_pkg;

  localparam int unsigned QueryIntervalW = 8;
  localparam int unsigned FrameW = 4;
  localparam int unsigned LevelW = 2;
  localparam int unsigned ByteW = 8;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  localparam logic [QueryIntervalW-1:0] QueryIntervalReset = 8'd8;
  localparam logic [FrameW-1:0] FrameLastReset = 4'd9;
  localparam logic [LevelW-1:0] LevelReset = 2'd1;

  localparam logic [LevelW-1:0] LevelLow = 2'd1;
  localparam logic [LevelW-1:0] LevelMid = 2'd2;
  localparam logic [LevelW-1:0] LevelHigh = 2'd3;

  localparam logic [ByteW-1:0] CharSpace = 8'h20;
  localparam logic [ByteW-1:0] CharComma = 8'h2c;
  localparam logic [ByteW-1:0] CharZero = 8'h30;
  localparam logic [ByteW-1:0] CharOne = 8'h31;
  localparam logic [ByteW-1:0] CharTwo = 8'h32;
  localparam logic [ByteW-1:0] CharThree = 8'h33;
  localparam logic [ByteW-1:0] CharFour = 8'h34;

  localparam logic OpTick = 1'b0;
  localparam logic OpByte = 1'b1;

  localparam logic RegQueryInterval = 1'b0;
  localparam logic RegFrameLast = 1'b1;

  typedef struct packed {
    logic             op;
    logic [ByteW-1:0] rx_byte;
  } slbi_in_t;

  typedef struct packed {
    logic              led_on;
    logic              send_query;
    logic [LevelW-1:0] shown_level;
    logic [LevelW-1:0] parsed_level;
  } slbi_out_t;

  typedef struct packed {
    logic arm;
    logic byte_en;
  } slbi_parse_cmd_t;

  typedef struct packed {
    logic              led;
    logic              query;
    logic [LevelW-1:0] shown;
  } slbi_blink_stat_t;

endpackage

[src/slbi_parser.sv]
`timescale 1ns / 1ps

module slbi_parser
  import slbi_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  slbi_parse_cmd_t       cmd_i,
  input  logic [ByteW-1:0]      rx_byte_i,
  output logic [LevelW-1:0]     parsed_lvl_d_o,
  output logic [LevelW-1:0]     parsed_lvl_q_o
);

  typedef enum logic [2:0] {
    PhOff,
    PhSpace,
    PhFirst,
    PhAfter1,
    PhAfter2,
    PhAfter3
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [LevelW-1:0] lvl_q, lvl_d;
  logic              is_comma, is_low_digit;

  assign is_comma = (rx_byte_i == CharComma);
  assign is_low_digit = (rx_byte_i >= CharZero) && (rx_byte_i <= CharFour);

  always_comb begin
    phase_d = phase_q;
    lvl_d = lvl_q;
    if (cmd_i.arm) begin
      phase_d = PhSpace;
    end else if (cmd_i.byte_en) begin
      unique case (phase_q)
        PhSpace: begin
          if (rx_byte_i == CharSpace) begin
            phase_d = PhFirst;
          end
        end
        PhFirst: begin
          if (rx_byte_i == CharOne) begin
            phase_d = PhAfter1;
          end else if (rx_byte_i == CharTwo) begin
            phase_d = PhAfter2;
          end else if (rx_byte_i == CharThree) begin
            phase_d = PhAfter3;
          end else begin
            lvl_d = LevelLow;
            phase_d = PhOff;
          end
        end
        PhAfter1: begin
          lvl_d = (is_comma || is_low_digit) ? LevelLow : LevelMid;
          phase_d = PhOff;
        end
        PhAfter2: begin
          if (is_comma) begin
            lvl_d = LevelLow;
          end else if (is_low_digit) begin
            lvl_d = LevelMid;
          end else begin
            lvl_d = LevelHigh;
          end
          phase_d = PhOff;
        end
        PhAfter3: begin
          lvl_d = is_comma ? LevelLow : LevelHigh;
          phase_d = PhOff;
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhOff;
      lvl_q <= LevelReset;
    end else begin
      phase_q <= phase_d;
      lvl_q <= lvl_d;
    end
  end

  assign parsed_lvl_d_o = lvl_d;
  assign parsed_lvl_q_o = lvl_q;

endmodule

[src/slbi_blink.sv]
`timescale 1ns / 1ps

module slbi_blink
  import slbi_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      tick_i,
  input  logic [QueryIntervalW-1:0] query_interval_i,
  input  logic [FrameW-1:0]         frame_last_i,
  input  logic [LevelW-1:0]         parsed_lvl_i,
  output slbi_blink_stat_t          stat_d_o
);

  logic [QueryIntervalW-1:0] tick_cnt_q, tick_cnt_d;
  logic [QueryIntervalW:0]   tick_next;
  logic [FrameW-1:0]         frame_pos_q, frame_pos_d;
  logic [LevelW-1:0]         shown_q, shown_d;
  logic                      led_q, led_d;
  logic [LevelW-1:0]         lvl;
  logic [FrameW:0]           flash_end;
  logic                      query;

  assign lvl = (shown_q == '0) ? LevelLow : shown_q;
  assign flash_end = {{(FrameW - LevelW){1'b0}}, lvl, 1'b0};
  assign query = tick_i && (tick_cnt_q == '0);
  assign tick_next = {1'b0, tick_cnt_q} + {{QueryIntervalW{1'b0}}, 1'b1};

  always_comb begin
    tick_cnt_d = tick_cnt_q;
    frame_pos_d = frame_pos_q;
    shown_d = shown_q;
    led_d = led_q;
    if (tick_i) begin
      if (tick_next >= {1'b0, query_interval_i}) begin
        tick_cnt_d = '0;
      end else begin
        tick_cnt_d = tick_next[QueryIntervalW-1:0];
      end
      if (!frame_pos_q[0] && ({1'b0, frame_pos_q} < flash_end)) begin
        led_d = 1'b1;
        frame_pos_d = frame_pos_q + {{(FrameW - 1){1'b0}}, 1'b1};
      end else if (frame_pos_q < frame_last_i) begin
        led_d = 1'b0;
        frame_pos_d = frame_pos_q + {{(FrameW - 1){1'b0}}, 1'b1};
      end else begin
        led_d = 1'b0;
        frame_pos_d = '0;
        shown_d = parsed_lvl_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_cnt_q <= '0;
      frame_pos_q <= '0;
      shown_q <= LevelReset;
      led_q <= 1'b0;
    end else begin
      tick_cnt_q <= tick_cnt_d;
      frame_pos_q <= frame_pos_d;
      shown_q <= shown_d;
      led_q <= led_d;
    end
  end

  assign stat_d_o.led = led_d;
  assign stat_d_o.query = query;
  assign stat_d_o.shown = shown_d;

endmodule

[src/signal_level_blink_indicator.sv]
`timescale 1ns / 1ps
// an item is held in the input register, then its result in the result register, where it is valid
// throughput: one item per cycle unless stalled; each updates counters and parser in one pass
// a full input register stalls the input side while a result waits to be taken
// reset: asynchronous active low, counters and frame cleared, levels at one, parser disarmed
// reset: query_interval 8 and frame_last 9

module signal_level_blink_indicator
  import slbi_pkg::*;
#(
  parameter logic [QueryIntervalW-1:0] QueryIntervalInit = QueryIntervalReset,
  parameter logic [FrameW-1:0]         FrameLastInit = FrameLastReset
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  slbi_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output slbi_out_t           out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  logic                      s1_valid_q;
  slbi_in_t                  s1_data_q;
  logic                      out_valid_q;
  slbi_out_t                 out_q;
  logic                      advance;
  logic [QueryIntervalW-1:0] query_interval_q;
  logic [FrameW-1:0]         frame_last_q;
  logic                      tick;
  slbi_parse_cmd_t           parse_cmd;
  slbi_blink_stat_t          blink_stat;
  logic [LevelW-1:0]         parsed_lvl_d, parsed_lvl_q;
  logic                      cfg_wr;

  assign advance = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign tick = advance && (s1_data_q.op == OpTick);

  // apb register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_interval_q <= QueryIntervalInit;
      frame_last_q <= FrameLastInit;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegQueryInterval: query_interval_q <= pwdata[QueryIntervalW-1:0];
        RegFrameLast: frame_last_q <= pwdata[FrameW-1:0];
        default: query_interval_q <= query_interval_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegQueryInterval: prdata = {{(ApbDataW - QueryIntervalW){1'b0}}, query_interval_q};
      RegFrameLast: prdata = {{(ApbDataW - FrameW){1'b0}}, frame_last_q};
      default: prdata = '0;
    endcase
  end

  slbi_blink u_blink (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tick_i           (tick),
    .query_interval_i (query_interval_q),
    .frame_last_i     (frame_last_q),
    .parsed_lvl_i     (parsed_lvl_q),
    .stat_d_o         (blink_stat)
  );

  assign parse_cmd.arm = blink_stat.query;
  assign parse_cmd.byte_en = advance && (s1_data_q.op == OpByte);

  slbi_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (parse_cmd),
    .rx_byte_i      (s1_data_q.rx_byte),
    .parsed_lvl_d_o (parsed_lvl_d),
    .parsed_lvl_q_o (parsed_lvl_q)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_data_q <= in_data_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.led_on <= blink_stat.led;
      out_q.send_query <= blink_stat.query;
      out_q.shown_level <= blink_stat.shown;
      out_q.parsed_level <= parsed_lvl_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

`ifndef ASSERT_OFF
  a_levels_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.shown_level != '0) && (out_data_o.parsed_level != '0))
    else $error("result level is zero");

  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled while pipeline not full");

  a_held_item_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> s1_valid_q && $stable(s1_data_q))
    else $error("stalled item dropped or changed");

  a_query_only_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_data_q.op == OpByte) |=> !out_data_o.send_query)
    else $error("query raised on byte item");
`endif

endmodule
